### rtl/core/rid_pkg.sv
// Shared types and codes for the reversible indexed deque.
package rid_pkg;

   localparam int MODE_W  = 4;
   localparam int DATA_W  = 64;
   localparam int POS_W   = 10;
   localparam int ERR_W   = 2;
   localparam int COUNT_W = 11;

   localparam logic [MODE_W-1:0] MODE_PUSH_LEFT  = 4'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_RIGHT = 4'd1;
   localparam logic [MODE_W-1:0] MODE_POP_LEFT   = 4'd2;
   localparam logic [MODE_W-1:0] MODE_POP_RIGHT  = 4'd3;
   localparam logic [MODE_W-1:0] MODE_PEEK_LEFT  = 4'd4;
   localparam logic [MODE_W-1:0] MODE_PEEK_RIGHT = 4'd5;
   localparam logic [MODE_W-1:0] MODE_READ_AT    = 4'd6;
   localparam logic [MODE_W-1:0] MODE_WRITE_AT   = 4'd7;
   localparam logic [MODE_W-1:0] MODE_REVERSE    = 4'd8;

   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
   localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd3;

   // status of a request while its store read is in flight
   typedef struct packed {
      logic               ok;
      logic [ERR_W-1:0]   error_code;
      logic               is_read;
      logic [COUNT_W-1:0] count;
      logic               is_empty;
   } rid_pend_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic                     ok;
      logic [ERR_W-1:0]         error_code;
      logic [COUNT_W-1:0]       count;
      logic                     is_empty;
   } rid_rsp_type;

endpackage

### rtl/core/rid_store.sv
// Entry store: single-port-write, registered-read memory of deque entries.
module rid_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [rid_pkg::DATA_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [rid_pkg::DATA_W-1:0]  rd_data
);
   import rid_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/reversible_indexed_deque.sv
// Reversible indexed deque top level: ring-buffer control around the entry store.
// An accepted request enters the pending register and moves into the response
// register once that is empty or its response is being taken.
// Throughput: one request per cycle while responses are taken; each request
// makes at most one access to the entry store (one write port, one read port).
// Reset (synchronous): left pointer, count, reversed view, pending and response
// valid flags clear; the store is not cleared; only written entries are read.
module reversible_indexed_deque #(
   parameter int CAPACITY = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [rid_pkg::MODE_W-1:0]         req_mode,
   input  logic signed [rid_pkg::DATA_W-1:0]  req_value,
   input  logic [rid_pkg::POS_W-1:0]          req_position,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [rid_pkg::DATA_W-1:0]  rsp_read_value,
   output logic                               rsp_ok,
   output logic [rid_pkg::ERR_W-1:0]          rsp_error_code,
   output logic [rid_pkg::COUNT_W-1:0]        rsp_count,
   output logic                               rsp_is_empty
);
   import rid_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = CW + 1;
   localparam int PW = (CW > POS_W) ? CW : POS_W;
   localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

   localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [AW-1:0] LAST  = AW'(CAPACITY - 1);

   logic [AW-1:0] lp_ff, lp_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rev_ff, rev_in;
   logic          pend_valid_ff;
   rid_pend_type  pend_ff, pend_in;
   logic          rsp_valid_ff;
   rid_rsp_type   rsp_ff;

   logic          accept, pend_adv;
   logic          at_left_push, at_left_end;
   logic          is_full, is_empty_now, range_bad;
   logic [AW-1:0] lp_dec, lp_inc;
   logic [PW-1:0] pos_ext, cnt_ext, off_rev;
   logic [CW-1:0] off_pos, off_sel;
   logic [SW-1:0] sum, sum_wrap;
   logic [AW-1:0] slot;
   logic          use_left_addr, wen, ren, ok, is_read;
   logic [ERR_W-1:0] err;
   logic [XW-1:0] cnt_x;
   logic [DATA_W-1:0] rd_data;

   assign pend_adv  = pend_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !pend_valid_ff || pend_adv;
   assign accept    = req_valid && req_ready;

   assign at_left_push = (req_mode == MODE_PUSH_LEFT) ^ rev_ff;
   assign at_left_end  = !req_mode[0] ^ rev_ff;
   assign is_full      = (cnt_ff == CAP_C);
   assign is_empty_now = (cnt_ff == '0);
   assign lp_dec       = (lp_ff == '0) ? LAST : lp_ff - AW'(1);
   assign lp_inc       = (lp_ff == LAST) ? '0 : lp_ff + AW'(1);

   // logical position to offset from stored left end, mirrored when reversed
   assign pos_ext   = PW'(req_position);
   assign cnt_ext   = PW'(cnt_ff);
   assign range_bad = (pos_ext >= cnt_ext);
   assign off_rev   = rev_ff ? (cnt_ext - pos_ext - PW'(1)) : pos_ext;
   assign off_pos   = off_rev[CW-1:0];

   // ring wrap: both terms below CAPACITY, so one subtract suffices
   assign sum      = SW'(lp_ff) + SW'(off_sel);
   assign sum_wrap = sum - CAP_S;
   assign slot     = (sum >= CAP_S) ? sum_wrap[AW-1:0] : sum[AW-1:0];

   always_comb begin
      lp_in         = lp_ff;
      cnt_in        = cnt_ff;
      rev_in        = rev_ff;
      ok            = 1'b0;
      err           = ERR_NONE;
      wen           = 1'b0;
      ren           = 1'b0;
      is_read       = 1'b0;
      use_left_addr = 1'b0;
      off_sel       = '0;
      case (req_mode)
         MODE_PUSH_LEFT, MODE_PUSH_RIGHT: begin
            if (is_full) begin
               err = ERR_FULL;
            end else begin
               ok     = 1'b1;
               wen    = 1'b1;
               cnt_in = cnt_ff + CW'(1);
               if (at_left_push) begin
                  lp_in         = lp_dec;
                  use_left_addr = 1'b1;
               end else begin
                  off_sel = cnt_ff;
               end
            end
         end
         MODE_POP_LEFT, MODE_POP_RIGHT: begin
            if (is_empty_now) begin
               err = ERR_EMPTY;
            end else begin
               ok     = 1'b1;
               cnt_in = cnt_ff - CW'(1);
               if (at_left_end) begin
                  lp_in = lp_inc;
               end
            end
         end
         MODE_PEEK_LEFT, MODE_PEEK_RIGHT: begin
            if (is_empty_now) begin
               err = ERR_EMPTY;
            end else begin
               ok      = 1'b1;
               ren     = 1'b1;
               is_read = 1'b1;
               off_sel = at_left_end ? '0 : cnt_ff - CW'(1);
            end
         end
         MODE_READ_AT, MODE_WRITE_AT: begin
            if (range_bad) begin
               err = ERR_RANGE;
            end else begin
               ok      = 1'b1;
               off_sel = off_pos;
               if (req_mode == MODE_READ_AT) begin
                  ren     = 1'b1;
                  is_read = 1'b1;
               end else begin
                  wen = 1'b1;
               end
            end
         end
         MODE_REVERSE: begin
            rev_in = !rev_ff;
            ok     = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign cnt_x = XW'(cnt_in);

   always_comb begin
      pend_in.ok         = ok;
      pend_in.error_code = err;
      pend_in.is_read    = is_read;
      pend_in.count      = cnt_x[COUNT_W-1:0];
      pend_in.is_empty   = (cnt_in == '0);
   end

   rid_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_rid_store (
      .clock   (clock),
      .wr_en   (accept && wen),
      .wr_addr (use_left_addr ? lp_dec : slot),
      .wr_data (req_value),
      .rd_en   (accept && ren),
      .rd_addr (slot),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_ff         <= '0;
         cnt_ff        <= '0;
         rev_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            lp_ff  <= lp_in;
            cnt_ff <= cnt_in;
            rev_ff <= rev_in;
         end
         if (accept) begin
            pend_valid_ff <= 1'b1;
         end else if (pend_adv) begin
            pend_valid_ff <= 1'b0;
         end
         if (pend_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
      if (pend_adv) begin
         rsp_ff.read_value <= pend_ff.is_read ? $signed(rd_data) : '0;
         rsp_ff.ok         <= pend_ff.ok;
         rsp_ff.error_code <= pend_ff.error_code;
         rsp_ff.count      <= pend_ff.count;
         rsp_ff.is_empty   <= pend_ff.is_empty;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_ff.read_value;
   assign rsp_ok         = rsp_ff.ok;
   assign rsp_error_code = rsp_ff.error_code;
   assign rsp_count      = rsp_ff.count;
   assign rsp_is_empty   = rsp_ff.is_empty;

endmodule

### rtl/core/rid_checker.sv
// Port-level checks for the reversible indexed deque, bound to the top level.
module rid_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [rid_pkg::DATA_W-1:0]  rsp_read_value,
   input logic                               rsp_ok,
   input logic [rid_pkg::ERR_W-1:0]          rsp_error_code,
   input logic [rid_pkg::COUNT_W-1:0]        rsp_count,
   input logic                               rsp_is_empty
);
   import rid_pkg::*;

   // nothing can be pending right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && req_ready))
      else $error("response valid or request blocked right after reset");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_count == '0)))
      else $error("empty flag disagrees with count");

   a_ok_no_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ok) |-> (rsp_error_code == ERR_NONE))
      else $error("completed request carries an error code");

   a_empty_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code == ERR_EMPTY) |-> rsp_is_empty)
      else $error("empty error on a nonempty queue");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_read_value) && $stable(rsp_ok) &&
          $stable(rsp_error_code) && $stable(rsp_count) && $stable(rsp_is_empty)))
      else $error("stalled response changed");

endmodule

bind reversible_indexed_deque rid_checker u_rid_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_read_value (rsp_read_value),
   .rsp_ok         (rsp_ok),
   .rsp_error_code (rsp_error_code),
   .rsp_count      (rsp_count),
   .rsp_is_empty   (rsp_is_empty)
);
